// ===== rtl/indexed_min_heap_decrease_key_unit_assert.svh =====
// Assertion macros for the indexed min-heap unit.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMH_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define IMH_ASSERT_IMPL(label, clk, rst, prop, msg)
`define IMH_ASSERT_NEXT(label, clk, rst, cond, nxt, msg)
`endif
`endif

// ===== rtl/imh_pkg.sv =====
// Shared types and constants for the indexed min-heap unit.
package imh_pkg;
   localparam int MaxVertices = 1024;
   localparam int SlotWidth = $clog2(MaxVertices);
   localparam int CountWidth = SlotWidth + 1;
   localparam int KeyWidth = 31;
   localparam int VertexWidth = 10;
   localparam int StatusWidth = 3;
   localparam logic [KeyWidth-1:0] KEY_MAX = {KeyWidth{1'b1}};

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DECREASE = 2'd1;
   localparam logic [1:0] REQ_EXTRACT = 2'd2;
   localparam logic [1:0] REQ_LOOKUP = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_ABSENT = 3'd2;
   localparam logic [2:0] ST_INCREASE = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   // datapath operations issued by the controller
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_READ_POS = 4'd1;   // read position map of req vertex
   localparam logic [3:0] OP_READ_CUR = 4'd2;   // read slot cur
   localparam logic [3:0] OP_READ_LAST = 4'd3;  // read slot count-1
   localparam logic [3:0] OP_READ_L = 4'd4;     // read left child
   localparam logic [3:0] OP_READ_R = 4'd5;     // read right child
   localparam logic [3:0] OP_READ_P = 4'd6;     // read parent
   localparam logic [3:0] OP_WRITE_CUR = 4'd7;  // write cur entry at slot cur
   localparam logic [3:0] OP_WRITE_OTHER = 4'd8; // write oth entry at cur, move cur
   localparam logic [3:0] OP_INIT = 4'd9;       // latch request
   localparam logic [3:0] OP_CLEAR = 4'd10;     // clear pass step

   typedef struct packed {
      logic [3:0] op;
      logic       set_key;     // cur entry <= request vertex and distance
      logic       count_inc;
      logic       count_dec;
      logic       drop_vertex; // mark result vertex absent
      logic       pos_write;   // write position of cur vertex
   } cmd_type;

   typedef struct packed {
      logic       held;
      logic       range_err;
      logic       empty;
      logic       full;
      logic       at_root;
      logic       has_l;
      logic       has_r;
      logic       other_less;  // oth key < cur key
      logic       cur_less;    // cur key < oth key
      logic       new_greater;
      logic       clear_done;
   } stat_type;
endpackage

// ===== rtl/imh_datapath.sv =====
// Heap memories, position map, count and result registers.
module imh_datapath
   import imh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic [1:0]             req_type,
   input  logic [VertexWidth-1:0] req_vertex,
   input  logic [KeyWidth-1:0]    req_distance,
   input  logic [StatusWidth-1:0] status_code,
   input  logic                   rsp_load,
   output logic [VertexWidth-1:0] res_vertex,
   output logic [KeyWidth-1:0]    res_distance,
   output logic                   res_found,
   output logic [StatusWidth-1:0] res_status,
   output logic [CountWidth-1:0]  res_count
);
   logic [KeyWidth-1:0]    key_mem [MaxVertices];
   logic [VertexWidth-1:0] vtx_mem [MaxVertices];
   logic [SlotWidth:0]     pos_mem [MaxVertices];  // msb: held

   logic [1:0]             type_ff;
   logic [VertexWidth-1:0] vreq_ff;
   logic [KeyWidth-1:0]    dreq_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [SlotWidth-1:0]   cur_ff, oth_ff, rd_slot_ff;
   logic [KeyWidth-1:0]    cur_key_ff, oth_key_ff, l_key_ff, rd_key_ff;
   logic [VertexWidth-1:0] cur_vtx_ff, oth_vtx_ff, rd_vtx_ff;
   logic [SlotWidth:0]     pos_rd_ff;
   logic [VertexWidth-1:0] res_v_ff;
   logic [KeyWidth-1:0]    res_d_ff, top_key_ff;
   logic                   found_ff;
   logic                   res_found_ff;
   logic [StatusWidth-1:0] res_status_ff;
   logic [SlotWidth-1:0]   clr_ff;
   logic [3:0]             last_op_ff;
   logic [VertexWidth-1:0] top_vtx_ff;
   logic                   out_range;

   logic [SlotWidth:0] lchild, rchild;
   logic [SlotWidth-1:0] parent;
   assign lchild = {cur_ff, 1'b1};
   assign rchild = {cur_ff, 1'b0} + {{SlotWidth{1'b0}}, 1'b1} + {{SlotWidth{1'b0}}, 1'b1};
   assign parent = (cur_ff - 1'b1) >> 1;
   assign out_range = (32'(vreq_ff) >= MaxVertices);

   // memory read and write
   logic [SlotWidth-1:0] rd_addr;
   always_comb begin
      case (cmd.op)
         OP_READ_LAST: rd_addr = SlotWidth'(count_ff - 1'b1);
         OP_READ_L:    rd_addr = lchild[SlotWidth-1:0];
         OP_READ_R:    rd_addr = rchild[SlotWidth-1:0];
         OP_READ_P:    rd_addr = parent;
         default:      rd_addr = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_vtx_ff <= vtx_mem[rd_addr];
      rd_slot_ff <= rd_addr;
      pos_rd_ff <= pos_mem[vreq_ff[SlotWidth-1:0]];
      if (cmd.op == OP_WRITE_CUR) begin
         key_mem[cur_ff] <= cur_key_ff;
         vtx_mem[cur_ff] <= cur_vtx_ff;
      end else if (cmd.op == OP_WRITE_OTHER) begin
         key_mem[cur_ff] <= oth_key_ff;
         vtx_mem[cur_ff] <= oth_vtx_ff;
      end
      if (cmd.op == OP_CLEAR) begin
         pos_mem[clr_ff] <= '0;
      end else if (cmd.drop_vertex) begin
         pos_mem[top_vtx_ff[SlotWidth-1:0]] <= '0;
      end else if (cmd.op == OP_WRITE_OTHER) begin
         pos_mem[oth_vtx_ff[SlotWidth-1:0]] <= {1'b1, cur_ff};
      end else if (cmd.pos_write) begin
         pos_mem[cur_vtx_ff[SlotWidth-1:0]] <= {1'b1, cur_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         clr_ff <= '0;
         last_op_ff <= OP_NONE;
      end else begin
         last_op_ff <= cmd.op;
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (cmd.count_inc) count_ff <= count_ff + 1'b1;
         else if (cmd.count_dec) count_ff <= count_ff - 1'b1;
      end
   end

   // working entries
   always_ff @(posedge clock) begin
      if (cmd.op == OP_INIT) begin
         type_ff <= req_type;
         vreq_ff <= req_vertex;
         dreq_ff <= req_distance;
      end
      // capture read data by what was issued last cycle
      case (last_op_ff)
         OP_READ_POS: begin
            // extract always starts at the root
            cur_ff <= (type_ff == REQ_EXTRACT) ? '0 : pos_rd_ff[SlotWidth-1:0];
            found_ff <= pos_rd_ff[SlotWidth] & ~out_range;
         end
         OP_READ_CUR: begin
            cur_key_ff <= rd_key_ff;
            cur_vtx_ff <= rd_vtx_ff;
            top_key_ff <= rd_key_ff;
            top_vtx_ff <= rd_vtx_ff;
         end
         OP_READ_LAST: begin
            if (type_ff != REQ_INSERT) begin
               cur_key_ff <= rd_key_ff;
               cur_vtx_ff <= rd_vtx_ff;
            end
         end
         OP_READ_L: begin
            l_key_ff <= rd_key_ff;
            oth_key_ff <= rd_key_ff;
            oth_vtx_ff <= rd_vtx_ff;
            oth_ff <= rd_slot_ff;
         end
         OP_READ_R: begin
            // keep the left child unless the right one is strictly smaller
            if (rd_key_ff < l_key_ff) begin
               oth_key_ff <= rd_key_ff;
               oth_vtx_ff <= rd_vtx_ff;
               oth_ff <= rd_slot_ff;
            end
         end
         OP_READ_P: begin
            oth_key_ff <= rd_key_ff;
            oth_vtx_ff <= rd_vtx_ff;
            oth_ff <= rd_slot_ff;
         end
         default: ;
      endcase
      if (cmd.set_key) begin
         cur_key_ff <= dreq_ff;
         cur_vtx_ff <= vreq_ff;
      end
      if (cmd.op == OP_INIT) cur_ff <= '0;
      if (cmd.op == OP_READ_LAST && type_ff == REQ_INSERT) begin
         cur_ff <= SlotWidth'(count_ff - 1'b1);
      end
      if (cmd.op == OP_WRITE_OTHER) cur_ff <= oth_ff;
      if (cmd.op == OP_INIT) found_ff <= 1'b0;
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         res_status_ff <= status_code;
         if (type_ff == REQ_EXTRACT) begin
            res_v_ff <= (status_code == ST_OK) ? top_vtx_ff : '0;
            res_d_ff <= (status_code == ST_OK) ? top_key_ff : KEY_MAX;
            res_found_ff <= (status_code == ST_OK);
         end else begin
            res_v_ff <= vreq_ff;
            res_found_ff <= found_ff;
            if (status_code == ST_RANGE || status_code == ST_ABSENT) res_d_ff <= KEY_MAX;
            else if (status_code == ST_INCREASE) res_d_ff <= top_key_ff;
            else if (type_ff == REQ_LOOKUP) res_d_ff <= found_ff ? top_key_ff : KEY_MAX;
            else res_d_ff <= dreq_ff;
         end
      end
   end

   assign res_vertex = res_v_ff;
   assign res_distance = res_d_ff;
   assign res_found = res_found_ff;
   assign res_status = res_status_ff;
   assign res_count = count_ff;

   assign stat.held = found_ff;
   assign stat.range_err = out_range;
   assign stat.empty = (count_ff == '0);
   assign stat.full = (32'(count_ff) >= MaxVertices);
   assign stat.at_root = (cur_ff == '0);
   assign stat.has_l = ({1'b0, lchild} < {1'b0, count_ff});
   assign stat.has_r = ({1'b0, rchild} < {1'b0, count_ff});
   assign stat.other_less = (oth_key_ff < cur_key_ff);
   assign stat.cur_less = (cur_key_ff < oth_key_ff);
   assign stat.new_greater = (dreq_ff > cur_key_ff);
   assign stat.clear_done = (clr_ff == {SlotWidth{1'b1}});
endmodule

// ===== rtl/imh_control.sv =====
// Request sequencer for the indexed min-heap unit.
module imh_control
   import imh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  stat_type               stat,
   output cmd_type                cmd,
   output logic [StatusWidth-1:0] status_code,
   output logic                   rsp_load
);
`include "indexed_min_heap_decrease_key_unit_assert.svh"
   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_POS = 5'd2;
   localparam logic [4:0] S_POS_W = 5'd3;
   localparam logic [4:0] S_DISPATCH = 5'd4;
   localparam logic [4:0] S_CUR_W = 5'd5;
   localparam logic [4:0] S_DECIDE = 5'd6;
   localparam logic [4:0] S_UP_RD = 5'd7;
   localparam logic [4:0] S_UP_W = 5'd8;
   localparam logic [4:0] S_UP_CMP = 5'd9;
   localparam logic [4:0] S_DN_L = 5'd10;
   localparam logic [4:0] S_DN_R = 5'd11;
   localparam logic [4:0] S_DN_W = 5'd12;
   localparam logic [4:0] S_DN_PICK = 5'd13;
   localparam logic [4:0] S_DN_CMP = 5'd14;
   localparam logic [4:0] S_SWAP = 5'd15;
   localparam logic [4:0] S_FINISH = 5'd16;
   localparam logic [4:0] S_RESP = 5'd17;
   localparam logic [4:0] S_LAST_W = 5'd18;
   localparam logic [4:0] S_EXT_W = 5'd19;
   localparam logic [4:0] S_DN_W2 = 5'd20;

   logic [4:0] state_ff, state_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [1:0] type_ff;
   logic up_ff, up_in;  // swap direction: up or down

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         status_ff <= ST_OK;
         up_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         up_ff <= up_in;
      end
      if (state_ff == S_IDLE && req_valid) type_ff <= req_type;
   end

   // sequence: sift steps read, then swap by writing both slots
   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      up_in = up_ff;
      cmd = '0;
      rsp_load = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_INIT;
               status_in = ST_OK;
               state_in = S_POS;
            end
         end
         S_POS: begin
            cmd.op = OP_READ_POS;
            state_in = S_POS_W;
         end
         S_POS_W: state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (type_ff == REQ_EXTRACT) begin
               if (stat.empty) begin
                  status_in = ST_EMPTY;
                  state_in = S_FINISH;
               end else begin
                  cmd.op = OP_READ_CUR;
                  state_in = S_LAST_W;
               end
            end else if (stat.range_err) begin
               status_in = ST_RANGE;
               state_in = S_FINISH;
            end else if (!stat.held) begin
               if (type_ff == REQ_DECREASE) begin
                  status_in = ST_ABSENT;
                  state_in = S_FINISH;
               end else if (type_ff == REQ_INSERT && !stat.full) begin
                  cmd.count_inc = 1'b1;
                  state_in = S_EXT_W;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.op = OP_READ_CUR;
               state_in = S_CUR_W;
            end
         end
         S_EXT_W: begin
            if (type_ff == REQ_INSERT) begin
               // new slot at the end; hold vertex in cur
               cmd.op = OP_READ_LAST;
               state_in = S_DECIDE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LAST_W: begin
            cmd.op = OP_READ_LAST;
            cmd.count_dec = 1'b1;
            state_in = S_DN_W2;
         end
         S_DN_W2: begin
            // move last entry to root and drop extracted vertex
            cmd.drop_vertex = 1'b1;
            state_in = S_DECIDE;
         end
         S_CUR_W: state_in = S_DECIDE;
         S_DECIDE: begin
            if (type_ff == REQ_EXTRACT) begin
               if (stat.empty) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.op = OP_WRITE_CUR;
                  cmd.pos_write = 1'b1;
                  state_in = S_DN_L;
               end
            end else if (type_ff == REQ_LOOKUP) begin
               state_in = S_FINISH;
            end else if (type_ff == REQ_DECREASE && stat.new_greater) begin
               status_in = ST_INCREASE;
               state_in = S_FINISH;
            end else begin
               cmd.set_key = 1'b1;
               // a new entry only rises; a held one moves by the sign of the change
               if (type_ff == REQ_INSERT && !stat.held) begin
                  state_in = S_UP_W;
               end else begin
                  state_in = stat.new_greater ? S_DN_W : S_UP_W;
               end
            end
         end
         S_DN_W: begin
            cmd.op = OP_WRITE_CUR;
            cmd.pos_write = 1'b1;
            state_in = S_DN_L;
         end
         S_UP_W: begin
            cmd.op = OP_WRITE_CUR;
            cmd.pos_write = 1'b1;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            if (stat.at_root) begin
               state_in = S_FINISH;
            end else begin
               cmd.op = OP_READ_P;
               up_in = 1'b1;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: state_in = S_DN_CMP;
         S_DN_L: begin
            up_in = 1'b0;
            if (!stat.has_l) begin
               state_in = S_FINISH;
            end else begin
               cmd.op = OP_READ_L;
               state_in = stat.has_r ? S_DN_R : S_DN_PICK;
            end
         end
         S_DN_R: begin
            cmd.op = OP_READ_R;
            state_in = S_DN_PICK;
         end
         S_DN_PICK: state_in = S_DN_CMP;
         S_DN_CMP: begin
            // oth holds the parent (up) or the smaller child (down)
            if (up_ff ? stat.cur_less : stat.other_less) begin
               state_in = S_SWAP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SWAP: begin
            // other entry into cur slot; cur moves to other slot
            cmd.op = OP_WRITE_OTHER;
            state_in = up_ff ? S_UP_W : S_DN_W;
         end
         S_FINISH: begin
            rsp_load = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign status_code = status_ff;

   `IMH_ASSERT_IMPL(a_excl, clock, reset, !(req_ready && rsp_valid), "ready during response")
   `IMH_ASSERT_NEXT(a_load, clock, reset, rsp_load, rsp_valid, "load not followed by valid")
   `IMH_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
endmodule

// ===== rtl/indexed_min_heap_decrease_key_unit.sv =====
// Indexed binary min-heap of (distance, vertex) pairs with decrease-key.
// One request is taken at a time; a new one is accepted only after the response
// to the last has been taken. A sift walks the heap over up to ten levels with
// 1024 entries, reading one slot at a time through the single read port of the
// slot memories.
// After reset a clearing pass runs over the position map before the first request.
module indexed_min_heap_decrease_key_unit
   import imh_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_type,
   input  logic [VertexWidth-1:0] req_vertex,
   input  logic [KeyWidth-1:0]    req_distance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VertexWidth-1:0] rsp_result_vertex,
   output logic [KeyWidth-1:0]    rsp_result_distance,
   output logic                   rsp_found,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [CountWidth-1:0]  rsp_count_after
);
   cmd_type cmd;
   stat_type stat;
   logic [StatusWidth-1:0] status_code;
   logic rsp_load;

   imh_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_type, .rsp_valid, .rsp_ready,
      .stat, .cmd, .status_code, .rsp_load
   );

   imh_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_type, .req_vertex, .req_distance,
      .status_code, .rsp_load,
      .res_vertex(rsp_result_vertex), .res_distance(rsp_result_distance),
      .res_found(rsp_found), .res_status(rsp_status), .res_count(rsp_count_after)
   );
endmodule

// ===== tb/sv/indexed_min_heap_decrease_key_unit_tb.sv =====
// Self-checking testbench for the indexed min-heap decrease-key unit.
module indexed_min_heap_decrease_key_unit_tb
   import imh_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 4000000;
   localparam int RandomItems = 1450;

   typedef struct packed {
      logic [VertexWidth-1:0] vertex;
      logic [KeyWidth-1:0]    distance;
      logic                   found;
      logic [StatusWidth-1:0] status;
      logic [CountWidth-1:0]  count;
   } heap_rsp_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [VertexWidth-1:0] vertex;
      logic [KeyWidth-1:0]    distance;
      logic                   typed;
      heap_rsp_type           rsp;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_type;
   logic [VertexWidth-1:0] req_vertex;
   logic [KeyWidth-1:0]    req_distance;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [VertexWidth-1:0] rsp_result_vertex;
   logic [KeyWidth-1:0]    rsp_result_distance;
   logic                   rsp_found;
   logic [StatusWidth-1:0] rsp_status;
   logic [CountWidth-1:0]  rsp_count_after;

   indexed_min_heap_decrease_key_unit dut (.*);

   // shadow heap
   logic [KeyWidth-1:0]    heap_key [MaxVertices];
   logic [VertexWidth-1:0] heap_vertex [MaxVertices];
   int unsigned            slot_of [MaxVertices];
   bit                     is_held [MaxVertices];
   int unsigned            heap_size;

   heap_rsp_type pending_rsp[$];
   int           mismatches;
   int           cycles;
   int           send_idle_pct;
   int           rsp_stall_pct;

   // directed rows; typed expectations only where they are obvious
   stim_row_type dir_rows [23] = '{
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b1, '{10'd0, KEY_MAX, 1'b0, ST_EMPTY, 11'd0}},
      '{REQ_LOOKUP, 10'd5, 31'd0, 1'b1, '{10'd5, KEY_MAX, 1'b0, ST_OK, 11'd0}},
      '{REQ_DECREASE, 10'd5, 31'd9, 1'b1, '{10'd5, KEY_MAX, 1'b0, ST_ABSENT, 11'd0}},
      '{REQ_INSERT, 10'd1023, KEY_MAX, 1'b1, '{10'd1023, KEY_MAX, 1'b0, ST_OK, 11'd1}},
      '{REQ_INSERT, 10'd0, 31'd0, 1'b1, '{10'd0, 31'd0, 1'b0, ST_OK, 11'd2}},
      '{REQ_INSERT, 10'd7, 31'd100, 1'b1, '{10'd7, 31'd100, 1'b0, ST_OK, 11'd3}},
      '{REQ_INSERT, 10'd8, 31'd100, 1'b0, '0},
      '{REQ_INSERT, 10'd9, 31'd50, 1'b0, '0},
      '{REQ_DECREASE, 10'd7, 31'd200, 1'b1, '{10'd7, 31'd100, 1'b1, ST_INCREASE, 11'd5}},
      '{REQ_DECREASE, 10'd7, 31'd100, 1'b0, '0},
      '{REQ_DECREASE, 10'd8, 31'd1, 1'b0, '0},
      '{REQ_INSERT, 10'd0, 31'd300, 1'b1, '{10'd0, 31'd300, 1'b1, ST_OK, 11'd5}},
      '{REQ_INSERT, 10'd9, 31'd0, 1'b0, '0},
      '{REQ_LOOKUP, 10'd9, 31'd0, 1'b0, '0},
      '{REQ_LOOKUP, 10'd1023, 31'd0, 1'b1, '{10'd1023, KEY_MAX, 1'b1, ST_OK, 11'd5}},
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b0, '0},
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b0, '0},
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b0, '0},
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b0, '0},
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b0, '0},
      '{REQ_EXTRACT, 10'd0, 31'd0, 1'b1, '{10'd0, KEY_MAX, 1'b0, ST_EMPTY, 11'd0}},
      '{REQ_INSERT, 10'd341, 31'h2AAA_AAAA, 1'b0, '0},
      '{REQ_INSERT, 10'd682, 31'h5555_5555, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [KeyWidth-1:0]    k;
      logic [VertexWidth-1:0] v;
      k = heap_key[a];
      v = heap_vertex[a];
      heap_key[a] = heap_key[b];
      heap_vertex[a] = heap_vertex[b];
      heap_key[b] = k;
      heap_vertex[b] = v;
      slot_of[heap_vertex[a]] = a;
      slot_of[heap_vertex[b]] = b;
   endfunction

   // move toward the root only on a strictly smaller key
   function automatic void bubble_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (heap_key[i] >= heap_key[p]) break;
         swap_slots(i, p);
         i = p;
      end
   endfunction

   // move toward the leaves; left child wins a tie
   function automatic void bubble_down(int unsigned i);
      int unsigned pick;
      int unsigned l;
      int unsigned r;
      forever begin
         pick = i;
         l = 2 * i + 1;
         r = 2 * i + 2;
         if (l < heap_size && heap_key[l] < heap_key[pick]) pick = l;
         if (r < heap_size && heap_key[r] < heap_key[pick]) pick = r;
         if (pick == i) break;
         swap_slots(i, pick);
         i = pick;
      end
   endfunction

   // apply one request to the shadow heap and return its response
   function automatic heap_rsp_type heap_apply(logic [1:0] kind, logic [VertexWidth-1:0] v,
                                               logic [KeyWidth-1:0] d);
      heap_rsp_type        res;
      int unsigned         s;
      int unsigned         last;
      logic [KeyWidth-1:0] old;
      res = '{v, KEY_MAX, 1'b0, ST_OK, '0};
      if (kind == REQ_EXTRACT) begin
         res.vertex = '0;
         if (heap_size == 0) begin
            res.status = ST_EMPTY;
         end else begin
            last = heap_size - 1;
            res.vertex = heap_vertex[0];
            res.distance = heap_key[0];
            res.found = 1'b1;
            is_held[heap_vertex[0]] = 1'b0;
            heap_key[0] = heap_key[last];
            heap_vertex[0] = heap_vertex[last];
            heap_size = last;
            if (heap_size > 0) begin
               slot_of[heap_vertex[0]] = 0;
               bubble_down(0);
            end
         end
      end else if (int'(v) >= MaxVertices) begin
         res.status = ST_RANGE;
      end else begin
         s = slot_of[v];
         res.found = is_held[v];
         if (kind == REQ_INSERT) begin
            res.distance = d;
            if (is_held[v]) begin
               old = heap_key[s];
               heap_key[s] = d;
               if (d < old) bubble_up(s);
               else if (d > old) bubble_down(s);
            end else if (heap_size < MaxVertices) begin
               s = heap_size;
               heap_key[s] = d;
               heap_vertex[s] = v;
               slot_of[v] = s;
               is_held[v] = 1'b1;
               heap_size = s + 1;
               bubble_up(s);
            end
         end else if (kind == REQ_DECREASE) begin
            if (!is_held[v]) begin
               res.status = ST_ABSENT;
            end else if (d > heap_key[s]) begin
               res.status = ST_INCREASE;
               res.distance = heap_key[s];
            end else begin
               heap_key[s] = d;
               res.distance = d;
               bubble_up(s);
            end
         end else if (is_held[v]) begin
            res.distance = heap_key[s];
         end
      end
      res.count = heap_size[CountWidth-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
      mismatches++;
   endtask

   // present one request, hold it until the transfer, record the expectation
   task automatic send_request(logic [1:0] kind, logic [VertexWidth-1:0] v,
                               logic [KeyWidth-1:0] d, bit typed, heap_rsp_type typed_rsp);
      heap_rsp_type pred;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_vertex <= v;
      req_distance <= d;
      do @(posedge clock); while (!req_ready);
      pred = heap_apply(kind, v, d);
      pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : pred);
   endtask

   // drop the request and wait until every expected response has come
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // check every response transfer against the oldest expectation
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_result_vertex !== want.vertex)
               report_mismatch("vertex", rsp_result_vertex, want.vertex);
            if (rsp_result_distance !== want.distance)
               report_mismatch("distance", rsp_result_distance, want.distance);
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_count_after !== want.count)
               report_mismatch("count_after", rsp_count_after, want.count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      logic [1:0]             kind;
      logic [VertexWidth-1:0] v;
      logic [KeyWidth-1:0]    d;
      int                     phase;
      int                     roll;
      heap_size = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < MaxVertices; i++) begin
         is_held[i] = 1'b0;
         slot_of[i] = 0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_INSERT;
      req_vertex = '0;
      req_distance = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      foreach (dir_rows[i])
         send_request(dir_rows[i].kind, dir_rows[i].vertex, dir_rows[i].distance,
                      dir_rows[i].typed, dir_rows[i].rsp);

      // random traffic in idling phases
      for (int n = 0; n < RandomItems; n++) begin
         phase = n / (RandomItems / 4);
         if (n % (RandomItems / 4) == 0) begin
            // before the stall phase, hold off until everything outstanding has come back
            if (phase == 2) drain_responses();
            case (phase)
               0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
               1: begin send_idle_pct = 83; rsp_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  rsp_stall_pct = 83; end
               default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
            endcase
         end
         roll = int'($urandom_range(99));
         if (phase == 0) begin
            // grow a large heap first
            kind = (roll < 75) ? REQ_INSERT : (roll < 85) ? REQ_DECREASE :
                   (roll < 93) ? REQ_EXTRACT : REQ_LOOKUP;
            v = 10'($urandom_range(1023));
         end else begin
            kind = (roll < 35) ? REQ_INSERT : (roll < 60) ? REQ_DECREASE :
                   (roll < 85) ? REQ_EXTRACT : REQ_LOOKUP;
            v = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(63));
         end
         if ($urandom_range(2) == 0) d = 31'($urandom_range(15));
         else d = 31'($urandom);
         // mostly aim decreases at a held vertex with a key not above its own
         if (kind == REQ_DECREASE && is_held[v] && $urandom_range(3) != 0)
            d = heap_key[slot_of[v]] - 31'($urandom_range(int'(heap_key[slot_of[v]] % 1000)));
         send_request(kind, v, d, 1'b0, '0);
      end

      drain_responses();
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_datapath.sv
rtl/imh_control.sv
rtl/indexed_min_heap_decrease_key_unit.sv
tb/sv/indexed_min_heap_decrease_key_unit_tb.sv
